// ===== rtl/ccla_pkg.sv =====
// shared types and constants for the lag alignment block
`default_nettype none
package ccla_pkg;
   typedef enum logic [1:0] {
      OP_WR_REF = 2'd0,
      OP_WR_DEG = 2'd1,
      OP_RD_DEG = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   localparam int IDX_W    = 8;
   localparam int SAMPLE_W = 16;
   localparam int LAG_W    = 7;
   localparam int PEAK_W   = 40;
   localparam int ACC_W    = 48;

   typedef struct packed {
      logic [1:0]                  opcode;
      logic [IDX_W-1:0]            sample_index;
      logic signed [SAMPLE_W-1:0]  sample_value;
   } req_type;

   typedef struct packed {
      logic                        aligned_now;
      logic [LAG_W-1:0]            align_lag;
      logic signed [PEAK_W-1:0]    peak_correlation;
      logic signed [SAMPLE_W-1:0]  aligned_sample;
   } rsp_type;

   // control from sequencer to the cell row
   typedef struct packed {
      logic clear;
      logic shift;
      logic valid;
   } cell_ctl_type;

   function automatic logic signed [PEAK_W-1:0] clamp40(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      begin
         hi = {{(ACC_W-PEAK_W+1){1'b0}}, {(PEAK_W-1){1'b1}}};
         lo = ~hi;
         if (v > hi) clamp40 = hi[PEAK_W-1:0];
         else if (v < lo) clamp40 = lo[PEAK_W-1:0];
         else clamp40 = v[PEAK_W-1:0];
      end
   endfunction
endpackage
`default_nettype wire

// ===== rtl/ccla_if.sv =====
// valid/ready channel interface
`default_nettype none
interface ccla_if #(parameter type payload_type = logic) (input wire logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/ccla_cell.sv =====
// one lag cell: holds a delayed degraded sample and its accumulator
`default_nettype none
module ccla_cell
   import ccla_pkg::*;
(
   input  wire logic                        clock,
   input  wire cell_ctl_type                ctl,
   input  wire logic signed [SAMPLE_W-1:0]  ref_sample,
   input  wire logic signed [SAMPLE_W-1:0]  deg_in,
   input  wire logic                        deg_vld_in,
   output logic signed [SAMPLE_W-1:0]       deg_out,
   output logic                             deg_vld_out,
   output logic signed [ACC_W-1:0]          acc_out
);
   logic signed [SAMPLE_W-1:0] deg_ff;
   logic                       vld_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic signed [ACC_W-1:0]    acc_in;
   logic signed [2*SAMPLE_W-1:0] prod;

   // product uses the sample this cell holds before the shift
   assign prod = ref_sample * deg_ff;

   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) acc_in = '0;
      else if (ctl.shift && ctl.valid && vld_ff)
         acc_in = acc_ff + {{(ACC_W-2*SAMPLE_W){prod[2*SAMPLE_W-1]}}, prod};
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (ctl.clear) vld_ff <= 1'b0;
      else if (ctl.shift) begin
         deg_ff <= deg_in;
         vld_ff <= deg_vld_in;
      end
   end

   assign deg_out     = deg_ff;
   assign deg_vld_out = vld_ff;
   assign acc_out     = acc_ff;
endmodule
`default_nettype wire

// ===== rtl/cross_correlation_lag_align.sv =====
// top level: frame stores, sequencer, lag cell row and peak scan
//
//  channel | dir | payload
//  req     | in  | opcode, sample_index, sample_value
//  rsp     | out | aligned_now, align_lag, peak_correlation, aligned_sample
//
// a write or an unused opcode passes from IDLE through RESP, a read through READ and then
// RESP; each returns to IDLE after RESP
// an alignment streams the frame through NLAG cells (MAX_LAG, capped at FRAME_LENGTH)
// in the feed state, then runs a peak scan over the cell accumulators
// the stores are memories with a registered read port, one read per cycle
// reset clears control and the held lag and peak; stores are not cleared
// a stalled response holds; no new request is taken until it drains
`default_nettype none
module cross_correlation_lag_align
   import ccla_pkg::*;
#(
   parameter int FRAME_LENGTH = 256,
   parameter int MAX_LAG      = 100
) (
   input wire logic clock,
   input wire logic reset,
   ccla_if.sink     req,
   ccla_if.source   rsp
);
   localparam int NLAG  = (MAX_LAG < FRAME_LENGTH) ? MAX_LAG : FRAME_LENGTH;
   localparam int ADDR_W = (FRAME_LENGTH > 1) ? $clog2(FRAME_LENGTH) : 1;
   localparam int CNT_W  = $clog2(FRAME_LENGTH + NLAG + 2);
   localparam int SCAN_W = $clog2(NLAG + 1);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_READ = 5'b00010,
      ST_FEED = 5'b00100,
      ST_SCAN = 5'b01000,
      ST_RESP = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic signed [SAMPLE_W-1:0] ref_mem [FRAME_LENGTH];
   logic signed [SAMPLE_W-1:0] deg_mem [FRAME_LENGTH];
   logic signed [SAMPLE_W-1:0] ref_rd_ff, deg_rd_ff;
   logic signed [SAMPLE_W-1:0] ref_dly_ff;

   logic                       ref_ready_ff;
   logic [LAG_W-1:0]           lag_ff;
   logic signed [PEAK_W-1:0]   peak_ff;
   logic [CNT_W-1:0]           cnt_ff;
   logic [SCAN_W-1:0]          scan_ff;
   logic                       feed_vld_ff;
   logic                       ref_dly_vld_ff;
   logic [LAG_W-1:0]           best_ff;
   logic signed [PEAK_W-1:0]   best_pk_ff;
   rsp_type                    rsp_ff;
   logic                       rsp_vld_ff;

   req_type  rq;
   logic     accept;
   logic     in_frame;
   logic     last_idx;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W+LAG_W:0] sum_addr;

   assign rq       = req.payload;
   assign accept   = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE) && !rsp_vld_ff;
   assign in_frame = 32'(rq.sample_index) < FRAME_LENGTH;
   assign last_idx = 32'(rq.sample_index) == FRAME_LENGTH - 1;

   // rotated read address, wraps once since index and lag are below frame
   assign sum_addr = (ADDR_W+LAG_W+1)'(rq.sample_index) + (ADDR_W+LAG_W+1)'(lag_ff);
   always_comb begin
      rd_addr = cnt_ff[ADDR_W-1:0];
      if (state_ff == ST_IDLE) begin
         if (32'(sum_addr) >= FRAME_LENGTH)
            rd_addr = ADDR_W'(32'(sum_addr) - FRAME_LENGTH);
         else
            rd_addr = ADDR_W'(sum_addr);
      end
   end

   // memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (accept && in_frame && opcode_type'(rq.opcode) == OP_WR_REF)
         ref_mem[rq.sample_index[ADDR_W-1:0]] <= rq.sample_value;
      if (accept && in_frame && opcode_type'(rq.opcode) == OP_WR_DEG)
         deg_mem[rq.sample_index[ADDR_W-1:0]] <= rq.sample_value;
      ref_rd_ff <= ref_mem[rd_addr];
      deg_rd_ff <= deg_mem[rd_addr];
      ref_dly_ff <= ref_rd_ff;
   end

   // cell row: degraded samples shift right, reference broadcast
   cell_ctl_type ctl;
   logic signed [SAMPLE_W-1:0] chain_d [NLAG+1];
   logic                       chain_v [NLAG+1];
   logic signed [ACC_W-1:0]    accs    [NLAG];

   assign ctl.clear = (state_ff == ST_IDLE) && accept;
   assign ctl.shift = (state_ff == ST_FEED);
   assign ctl.valid = ref_dly_vld_ff;
   assign chain_d[0] = deg_rd_ff;
   assign chain_v[0] = feed_vld_ff;

   // cell g holds deg[i-g] while the delayed reference carries ref[i]
   genvar g;
   generate
      for (g = 0; g < NLAG; g++) begin : g_cell
         ccla_cell u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .ref_sample  (ref_dly_ff),
            .deg_in      (chain_d[g]),
            .deg_vld_in  (chain_v[g]),
            .deg_out     (chain_d[g+1]),
            .deg_vld_out (chain_v[g+1]),
            .acc_out     (accs[g])
         );
      end
   endgenerate

   // the cell's own register adds a stage to the degraded path,
   // so the reference passes through ref_dly_ff to line up lag g in cell g
   logic signed [SAMPLE_W-1:0] unused_d;
   logic                       unused_v;
   assign unused_d = chain_d[NLAG];
   assign unused_v = chain_v[NLAG];

   logic signed [PEAK_W-1:0] scan_pk;
   logic [$clog2(NLAG+1)-1:0] scan_idx;
   assign scan_idx = scan_ff;
   assign scan_pk  = clamp40(accs[scan_idx[$clog2(NLAG+1)-1:0] < NLAG ?
                     scan_idx : '0]);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) begin
            if (opcode_type'(rq.opcode) == OP_RD_DEG && in_frame) state_in = ST_READ;
            else if (opcode_type'(rq.opcode) == OP_WR_DEG && in_frame && last_idx
                     && ref_ready_ff) state_in = ST_FEED;
            else state_in = ST_RESP;
         end
         ST_READ: state_in = ST_RESP;
         ST_FEED: if (32'(cnt_ff) == FRAME_LENGTH + 1) state_in = ST_SCAN;
         ST_SCAN: if (32'(scan_ff) == NLAG - 1) state_in = ST_RESP;
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         ref_ready_ff   <= 1'b0;
         lag_ff         <= '0;
         peak_ff        <= '0;
         rsp_vld_ff     <= 1'b0;
         feed_vld_ff    <= 1'b0;
         ref_dly_vld_ff <= 1'b0;
         cnt_ff         <= '0;
         scan_ff        <= '0;
         rsp_ff         <= '0;
      end else begin
         state_ff       <= state_in;
         ref_dly_vld_ff <= feed_vld_ff;
         if (rsp_vld_ff && rsp.ready) rsp_vld_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: if (accept) begin
               cnt_ff      <= '0;
               scan_ff     <= '0;
               feed_vld_ff <= 1'b0;
               rsp_ff.aligned_now    <= 1'b0;
               rsp_ff.aligned_sample <= '0;
               if (opcode_type'(rq.opcode) == OP_WR_REF && in_frame && last_idx)
                  ref_ready_ff <= 1'b1;
            end
            ST_READ: begin
               // rotated sample read at the accepting edge
               rsp_ff.aligned_sample <= deg_rd_ff;
            end
            ST_FEED: begin
               // read address cnt goes out, data valid next cycle
               cnt_ff      <= cnt_ff + 1'b1;
               feed_vld_ff <= 32'(cnt_ff) < FRAME_LENGTH;
            end
            ST_SCAN: begin
               scan_ff <= scan_ff + 1'b1;
               if (scan_ff == '0 || scan_pk > best_pk_ff) begin
                  best_pk_ff <= scan_pk;
                  best_ff    <= LAG_W'(scan_ff);
               end
               if (32'(scan_ff) == NLAG - 1) begin
                  rsp_ff.aligned_now <= 1'b1;
                  if (scan_ff == '0 || scan_pk > best_pk_ff) begin
                     lag_ff  <= LAG_W'(scan_ff);
                     peak_ff <= scan_pk;
                  end else begin
                     lag_ff  <= best_ff;
                     peak_ff <= best_pk_ff;
                  end
               end
            end
            ST_RESP: begin
               rsp_vld_ff               <= 1'b1;
               rsp_ff.align_lag         <= lag_ff;
               rsp_ff.peak_correlation  <= peak_ff;
            end
            default: ;
         endcase
      end
   end

   assign rsp.valid   = rsp_vld_ff;
   assign rsp.payload = rsp_ff;

   // the reference latch only ever rises outside reset
   assert property (@(posedge clock) disable iff (reset)
      $past(ref_ready_ff) |-> ref_ready_ff)
      else $error("reference ready dropped");
   assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> !req.ready)
      else $error("request taken while response pending");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FEED) |-> !rsp_vld_ff)
      else $error("response during feed");
endmodule
`default_nettype wire
